// ===== rtl/core/ddo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry package
// Shared widths, register indexes, reset values and the CORDIC angle table.
// ----------------------------------------------------------------------------
package ddo_pkg;

   localparam int CountWidth = 16;
   localparam int PosWidth   = 48;
   localparam int AngWidth   = 32;
   localparam int CsrWidth   = 32;
   localparam int CsrIdxWidth = 3;
   localparam int CordicStepsDefault = 16;
   localparam int AtanEntries = 30;

   // Register indexes.
   localparam logic [CsrIdxWidth-1:0] RegLeftStep  = 3'd0;
   localparam logic [CsrIdxWidth-1:0] RegRightStep = 3'd1;
   localparam logic [CsrIdxWidth-1:0] RegTurnGain  = 3'd2;
   localparam logic [CsrIdxWidth-1:0] RegUseGyro   = 3'd3;
   localparam logic [CsrIdxWidth-1:0] RegGyroBias  = 3'd4;
   localparam logic [CsrIdxWidth-1:0] RegGyroGain  = 3'd5;

   localparam logic [23:0] LeftStepReset  = 24'd732;
   localparam logic [23:0] RightStepReset = 24'd732;
   localparam logic [31:0] TurnGainReset  = 32'd71205000;
   localparam logic [23:0] GyroGainReset  = 24'd68359;

   // Start vector of the rotation, Q2.30.
   localparam logic signed [33:0] CordicStart = 34'sd652032874;

   // Configuration register set.
   typedef struct packed {
      logic [23:0]        left_step;
      logic [23:0]        right_step;
      logic [31:0]        turn_gain;
      logic               use_gyro;
      logic signed [15:0] gyro_bias;
      logic [23:0]        gyro_gain;
   } cfg_type;

   // Arctangent of two to the minus i, as a binary angle.
   function automatic logic [31:0] atan_turn(input logic [4:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;  5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003;  5'd29: r = 32'h00000001;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/core/ddo_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry channels
// Valid/ready interfaces for the count item and the pose item.
// ----------------------------------------------------------------------------
interface ddo_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [ddo_pkg::CountWidth-1:0] left_count;
   logic signed [ddo_pkg::CountWidth-1:0] right_count;
   logic signed [ddo_pkg::CountWidth-1:0] gyro_rate;
   modport source (output valid, left_count, right_count, gyro_rate, input ready);
   modport sink (input valid, left_count, right_count, gyro_rate, output ready);
endinterface

interface ddo_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [ddo_pkg::PosWidth-1:0] x_pos;
   logic signed [ddo_pkg::PosWidth-1:0] y_pos;
   logic [ddo_pkg::AngWidth-1:0]        heading;
   modport source (output valid, x_pos, y_pos, heading, input ready);
   modport sink (input valid, x_pos, y_pos, heading, output ready);
endinterface

// ===== rtl/core/differential_drive_odometry_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Differential-drive odometry
// Integrates wheel counts, and in gyro mode the gyro rate, into an x, y and heading pose.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake    Content
//   req      in         valid/ready  left_count, right_count, gyro_rate
//   rsp      out        valid/ready  x_pos, y_pos, heading
//   csr      in         write only   csr_we, csr_idx, csr_wdata
//
// A new item is accepted only once the last one has gone through five
// passes of the bit-serial multiplier (two distances, the heading step and
// the low halves of the two position terms), the CORDIC iterations and the
// hand-over between steps. Reset is synchronous; it clears the pose and the
// previous counts and loads the registers with their reset values. A result
// not yet taken stalls the final state; the result then waits in its output
// register while a new item is accepted.
// ----------------------------------------------------------------------------
module differential_drive_odometry_top #(
   parameter int CordicSteps = ddo_pkg::CordicStepsDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   ddo_req_if.sink                           req,
   ddo_rsp_if.source                         rsp,
   input  logic                              csr_we,
   input  logic [ddo_pkg::CsrIdxWidth-1:0]   csr_idx,
   input  logic [ddo_pkg::CsrWidth-1:0]      csr_wdata
);
   typedef enum logic [8:0] {
      StIdle  = 9'b000000001,
      StDl    = 9'b000000010,
      StDr    = 9'b000000100,
      StInc   = 9'b000001000,
      StRot   = 9'b000010000,
      StXlo   = 9'b000100000,
      StXhi   = 9'b001000000,
      StYlo   = 9'b010000000,
      StYhi   = 9'b100000000
   } state_type;

   state_type        st_ff, st_in;
   ddo_pkg::cfg_type cfg_ff;

   logic signed [47:0] px_ff, py_ff;
   logic [31:0]        ang_ff;
   logic [15:0]        ll_ff, lr_ff;
   logic [15:0]        lc_ff, rc_ff;
   logic signed [15:0] g_ff;
   logic signed [41:0] dl_ff, dr_ff;
   logic signed [33:0] cs_ff, sn_ff;
   logic signed [48:0] part_ff;
   logic               busy_mul_ff;
   logic               out_v_ff;
   logic signed [47:0] ox_ff, oy_ff;
   logic [31:0]        oh_ff;

   logic                mstart;
   logic signed [43:0]  ma;
   logic [31:0]         mb;
   logic                mdone;
   logic signed [75:0]  mp;
   logic                cstart, cdone;
   logic signed [33:0]  ccos, csin;
   logic signed [41:0]  dm;
   logic signed [42:0]  ddiff;
   logic signed [16:0]  gcorr;
   logic [31:0]         inc;
   logic signed [26:0]  dm_hi;
   logic signed [48:0]  part_lo;
   logic signed [47:0]  step_x;
   logic                out_free;
   logic signed [75:0]  lo_prod;
   logic                cs_or_sn_neg;
   logic signed [60:0]  hi_prod;

   ddo_serial_mul #(.AW(44), .BW(32)) u_mul (
      .clock(clock), .reset(reset), .start(mstart), .a(ma), .b(mb),
      .done(mdone), .p(mp)
   );

   ddo_cordic #(.CordicSteps(CordicSteps)) u_cordic (
      .clock(clock), .reset(reset), .start(cstart), .angle(ang_ff),
      .done(cdone), .cos_out(ccos), .sin_out(csin)
   );

   assign out_free  = !out_v_ff || rsp.ready;
   assign req.ready = (st_ff == StIdle);
   assign dm        = 42'((43'(dl_ff) + 43'(dr_ff)) >>> 1);
   assign ddiff     = 43'(dr_ff) - 43'(dl_ff);
   assign gcorr     = 17'(g_ff) - 17'(cfg_ff.gyro_bias);
   assign dm_hi     = 27'(dm >>> 15);

   // Operand selection for the shared multiplier.
   always_comb begin
      ma = '0;
      mb = '0;
      unique case (st_ff)
         StIdle: begin
            ma = 44'($signed(16'(req.left_count - ll_ff)));
            mb = {8'd0, cfg_ff.left_step};
         end
         StDl: begin
            ma = 44'($signed(16'(rc_ff - lr_ff)));
            mb = {8'd0, cfg_ff.right_step};
         end
         StInc: begin
            if (cfg_ff.use_gyro) begin
               ma = 44'(gcorr);
               mb = {8'd0, cfg_ff.gyro_gain};
            end else begin
               ma = 44'(ddiff);
               mb = cfg_ff.turn_gain;
            end
         end
         StRot: begin
            ma = 44'($signed({1'b0, dm[14:0]}));
            mb = ccos[31:0];
         end
         StXlo: begin
            ma = 44'($signed({1'b0, dm[14:0]}));
            mb = cs_ff[31:0];
         end
         StXhi: begin
            ma = 44'($signed({1'b0, dm[14:0]}));
            mb = sn_ff[31:0];
         end
         StYlo: begin
            ma = 44'($signed({1'b0, dm[14:0]}));
            mb = sn_ff[31:0];
         end
         default: begin
            ma = '0;
            mb = '0;
         end
      endcase
   end

   // Signed by signed low part: unsigned product minus the sign correction.
   assign cs_or_sn_neg = (st_ff == StXlo) ? cs_ff[33] : sn_ff[33];
   assign lo_prod = mp - (cs_or_sn_neg ? (76'(dm[14:0]) <<< 32) : '0);
   assign part_lo = 49'(lo_prod >>> 15);

   // Full-width signed product of the high part; a narrow exact multiply.
   assign hi_prod = dm_hi * ((st_ff == StXhi) ? cs_ff : sn_ff);
   assign step_x  = 48'((61'(hi_prod) + 61'(part_ff)) >>> 15);

   // Heading step: low word of the gyro product, or the wheel product over 2^16.
   assign inc = (cfg_ff.use_gyro) ? mp[31:0] : mp[47:16];

   // Sequencer: distances, heading, rotation, then the two position terms.
   always_comb begin
      st_in  = st_ff;
      mstart = 1'b0;
      cstart = 1'b0;
      unique case (st_ff)
         StIdle: if (req.valid) begin
            mstart = 1'b1;
            st_in  = StDl;
         end
         StDl: if (mdone) begin
            mstart = 1'b1;
            st_in  = StDr;
         end
         StDr: if (mdone) begin
            st_in = StInc;
         end
         StInc: begin
            if (!busy_mul_ff) begin
               mstart = 1'b1;
            end else if (mdone) begin
               st_in = StRot;
            end
         end
         StRot: begin
            if (!busy_mul_ff) begin
               cstart = 1'b1;
            end else if (cdone) begin
               mstart = 1'b1;
               st_in  = StXlo;
            end
         end
         StXlo: if (mdone) begin
            st_in = StXhi;
         end
         StXhi: begin
            mstart = 1'b1;
            st_in  = StYlo;
         end
         StYlo: if (mdone) begin
            st_in = StYhi;
         end
         StYhi: if (out_free) begin
            st_in = StIdle;
         end
         default: st_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= StIdle;
         px_ff       <= '0;
         py_ff       <= '0;
         ang_ff      <= '0;
         ll_ff       <= '0;
         lr_ff       <= '0;
         out_v_ff    <= 1'b0;
         busy_mul_ff <= 1'b0;
         cfg_ff.left_step  <= ddo_pkg::LeftStepReset;
         cfg_ff.right_step <= ddo_pkg::RightStepReset;
         cfg_ff.turn_gain  <= ddo_pkg::TurnGainReset;
         cfg_ff.use_gyro   <= 1'b0;
         cfg_ff.gyro_bias  <= '0;
         cfg_ff.gyro_gain  <= ddo_pkg::GyroGainReset;
      end else begin
         st_ff <= st_in;
         if (rsp.ready && st_ff != StYhi) begin
            out_v_ff <= 1'b0;
         end
         // Register writes.
         if (csr_we) begin
            unique case (csr_idx)
               ddo_pkg::RegLeftStep:  cfg_ff.left_step  <= csr_wdata[23:0];
               ddo_pkg::RegRightStep: cfg_ff.right_step <= csr_wdata[23:0];
               ddo_pkg::RegTurnGain:  cfg_ff.turn_gain  <= csr_wdata;
               ddo_pkg::RegUseGyro:   cfg_ff.use_gyro   <= csr_wdata[0];
               ddo_pkg::RegGyroBias:  cfg_ff.gyro_bias  <= csr_wdata[15:0];
               ddo_pkg::RegGyroGain:  cfg_ff.gyro_gain  <= csr_wdata[23:0];
               default: ;
            endcase
         end
         if (st_ff == StIdle && req.valid) begin
            lc_ff <= req.left_count;
            rc_ff <= req.right_count;
            g_ff  <= req.gyro_rate;
         end
         if (st_ff == StDl && mdone) begin
            dl_ff <= mp[41:0];
         end
         if (st_ff == StDr && mdone) begin
            dr_ff <= mp[41:0];
         end
         // The heading product is started in the first cycle of its state.
         if (st_ff == StInc) begin
            if (!busy_mul_ff) begin
               busy_mul_ff <= 1'b1;
            end else if (mdone) begin
               ang_ff      <= ang_ff + inc;
               busy_mul_ff <= 1'b0;
            end
         end
         // The CORDIC is started once, in the first cycle of the rotation state.
         if (st_ff == StRot) begin
            if (!busy_mul_ff) begin
               busy_mul_ff <= 1'b1;
            end else if (cdone) begin
               cs_ff       <= ccos;
               sn_ff       <= csin;
               busy_mul_ff <= 1'b0;
            end
         end
         if (st_ff == StXlo && mdone) begin
            part_ff <= part_lo;
         end
         if (st_ff == StXhi) begin
            px_ff <= px_ff + step_x;
         end
         if (st_ff == StYlo && mdone) begin
            part_ff <= part_lo;
         end
         if (st_ff == StYhi && out_free) begin
            py_ff    <= py_ff + step_x;
            ox_ff    <= px_ff;
            oy_ff    <= py_ff + step_x;
            oh_ff    <= ang_ff;
            ll_ff    <= lc_ff;
            lr_ff    <= rc_ff;
            out_v_ff <= 1'b1;
         end
      end
   end

   assign rsp.valid   = out_v_ff;
   assign rsp.x_pos   = ox_ff;
   assign rsp.y_pos   = oy_ff;
   assign rsp.heading = oh_ff;

   // A result is only raised from the final sequencer state.
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(out_v_ff) |-> $past(st_ff) == StYhi)
      else $error("result raised outside the final state");

   // The block takes no item while it is working on one.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("item accepted while busy");

   // A pending result is not overwritten.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !rsp.ready) |=> out_v_ff && $stable(ox_ff))
      else $error("pending result lost");
endmodule

// ===== rtl/core/ddo_serial_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial multiplier
// Signed by unsigned shift-and-add multiplier, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module ddo_serial_mul #(
   parameter int AW = 34,
   parameter int BW = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [AW-1:0]    a,
   input  logic [BW-1:0]           b,
   output logic                    done,
   output logic signed [AW+BW-1:0] p
);
   localparam int CW = $clog2(BW + 1);

   logic signed [AW+BW-1:0] acc_ff, acc_in;
   logic signed [AW+BW-1:0] mcand_ff, mcand_in;
   logic [BW-1:0]           mplr_ff, mplr_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;

   // One partial product is added per cycle, least significant bit first.
   always_comb begin
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      mplr_in  = mplr_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      if (start) begin
         acc_in   = '0;
         mcand_in = (AW+BW)'(a);
         mplr_in  = b;
         cnt_in   = CW'(BW);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (mplr_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in = mcand_ff <<< 1;
         mplr_in  = mplr_ff >> 1;
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      mplr_ff  <= mplr_in;
   end

   // The last partial product is folded in combinationally on the final cycle.
   assign done = busy_ff && (cnt_ff == CW'(1));
   assign p    = mplr_ff[0] ? acc_ff + mcand_ff : acc_ff;
endmodule

// ===== rtl/core/ddo_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative CORDIC
// Rotation-mode CORDIC giving cosine and sine of a binary angle, Q2.30,
// one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module ddo_cordic #(
   parameter int CordicSteps = ddo_pkg::CordicStepsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [31:0]         angle,
   output logic                done,
   output logic signed [33:0]  cos_out,
   output logic signed [33:0]  sin_out
);
   localparam int CW = $clog2(CordicSteps + 1);

   logic signed [33:0] x_ff, x_in, y_ff, y_in;
   logic signed [32:0] z_ff, z_in;
   logic [CW-1:0]      i_ff, i_in;
   logic               busy_ff, busy_in, flip_ff, flip_in;
   logic [31:0]        at;
   logic [31:0]        a_fold;
   logic               flip_now;

   assign flip_now = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
   assign a_fold   = flip_now ? angle - 32'h80000000 : angle;
   assign at       = ddo_pkg::atan_turn(5'(i_ff));

   // One micro-rotation a cycle; the shift is arithmetic, so it floors.
   always_comb begin
      x_in = x_ff; y_in = y_ff; z_in = z_ff;
      i_in = i_ff; busy_in = busy_ff; flip_in = flip_ff;
      if (start) begin
         x_in    = ddo_pkg::CordicStart;
         y_in    = '0;
         z_in    = 33'($signed(a_fold));
         i_in    = '0;
         flip_in = flip_now;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[32]) begin
            x_in = x_ff - (y_ff >>> i_ff);
            y_in = y_ff + (x_ff >>> i_ff);
            z_in = z_ff - $signed({1'b0, at});
         end else begin
            x_in = x_ff + (y_ff >>> i_ff);
            y_in = y_ff - (x_ff >>> i_ff);
            z_in = z_ff + $signed({1'b0, at});
         end
         i_in = i_ff + 1'b1;
         if (i_ff == CW'(CordicSteps - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         i_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         i_ff    <= i_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
   end

   assign done    = !busy_ff;
   assign cos_out = flip_ff ? -x_ff : x_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;
endmodule

// ===== sim/differential_drive_odometry_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry testbench
// Drives count items into the odometry block through several register
// settings, with random idling on both channels, and compares each pose item
// with a pose worked out by an independent fixed-point odometry predictor.
// ----------------------------------------------------------------------------
module differential_drive_odometry_top_tb;

   localparam int NumSteps    = ddo_pkg::CordicStepsDefault;
   localparam int SettleTicks = 400;
   localparam int StallLimit  = 20000;

   // Indexes that name no register.
   localparam logic [ddo_pkg::CsrIdxWidth-1:0] RegSpareLo = 3'd6;
   localparam logic [ddo_pkg::CsrIdxWidth-1:0] RegSpareHi = 3'd7;

   localparam logic [31:0] ArcTurns [16] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
   };

   typedef struct {
      logic [ddo_pkg::PosWidth-1:0] x;
      logic [ddo_pkg::PosWidth-1:0] y;
      logic [ddo_pkg::AngWidth-1:0] h;
   } pose_type;

   // Pose predictor and store of expected poses.
   class odo_scoreboard;
      logic [23:0]                  left_step, right_step, gyro_gain;
      logic [31:0]                  turn_gain;
      logic                         use_gyro;
      logic signed [15:0]           gyro_bias;
      logic [ddo_pkg::PosWidth-1:0] pos_x, pos_y;
      logic [ddo_pkg::AngWidth-1:0] angle;
      logic [15:0]                  last_left, last_right;
      pose_type                     poses_due[$];
      int                           errors;

      function new();
         left_step  = ddo_pkg::LeftStepReset;
         right_step = ddo_pkg::RightStepReset;
         turn_gain  = ddo_pkg::TurnGainReset;
         use_gyro   = 1'b0;
         gyro_bias  = '0;
         gyro_gain  = ddo_pkg::GyroGainReset;
         pos_x      = '0;
         pos_y      = '0;
         angle      = '0;
         last_left  = '0;
         last_right = '0;
         errors     = 0;
      endfunction

      function void write_reg(logic [ddo_pkg::CsrIdxWidth-1:0] idx,
                              logic [ddo_pkg::CsrWidth-1:0] v);
         case (idx)
            ddo_pkg::RegLeftStep:  left_step  = v[23:0];
            ddo_pkg::RegRightStep: right_step = v[23:0];
            ddo_pkg::RegTurnGain:  turn_gain  = v;
            ddo_pkg::RegUseGyro:   use_gyro   = v[0];
            ddo_pkg::RegGyroBias:  gyro_bias  = v[15:0];
            ddo_pkg::RegGyroGain:  gyro_gain  = v[23:0];
            default: ;
         endcase
      endfunction

      // Rotation-mode CORDIC on a binary angle folded to within a quarter turn of zero.
      function void rotate(logic [31:0] a, output longint cs, output longint sn);
         logic [31:0] folded;
         longint      vx, vy, vz, nx;
         bit          flip;
         flip   = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
         folded = flip ? a - 32'h80000000 : a;
         vx = longint'(ddo_pkg::CordicStart);
         vy = 0;
         vz = longint'($signed(folded));
         for (int i = 0; i < NumSteps; i++) begin
            if (vz >= 0) begin
               nx = vx - (vy >>> i);
               vy = vy + (vx >>> i);
               vz = vz - longint'(ArcTurns[i]);
            end else begin
               nx = vx + (vy >>> i);
               vy = vy - (vx >>> i);
               vz = vz + longint'(ArcTurns[i]);
            end
            vx = nx;
         end
         cs = flip ? -vx : vx;
         sn = flip ? -vy : vy;
      endfunction

      // Advance the pose by one accepted count item.
      function void note_item(logic [15:0] lc, logic [15:0] rc, logic [15:0] gr);
         logic [15:0]        dlc, drc;
         longint             cl, cr, dl, dr, dm, g, cs, sn;
         logic [63:0]        p;
         logic [31:0]        inc;
         logic signed [95:0] dw, cw, px, py;
         pose_type           pz;
         dlc = lc - last_left;
         drc = rc - last_right;
         cl  = longint'($signed(dlc));
         cr  = longint'($signed(drc));
         dl  = cl * longint'(left_step);
         dr  = cr * longint'(right_step);
         dm  = (dl + dr) >>> 1;
         if (use_gyro) begin
            g   = longint'($signed(gr)) - longint'(gyro_bias);
            p   = g * longint'(gyro_gain);
            inc = p[31:0];
         end else begin
            p   = (dr - dl) * longint'(turn_gain);
            inc = p[47:16];
         end
         angle = angle + inc;
         rotate(angle, cs, sn);
         dw = dm;
         cw = cs;
         px = (dw * cw) >>> 30;
         cw = sn;
         py = (dw * cw) >>> 30;
         pos_x = pos_x + px[ddo_pkg::PosWidth-1:0];
         pos_y = pos_y + py[ddo_pkg::PosWidth-1:0];
         last_left  = lc;
         last_right = rc;
         pz.x = pos_x;
         pz.y = pos_y;
         pz.h = angle;
         poses_due.push_back(pz);
      endfunction

      function void check_pose(logic [ddo_pkg::PosWidth-1:0] x,
                               logic [ddo_pkg::PosWidth-1:0] y,
                               logic [ddo_pkg::AngWidth-1:0] h);
         pose_type pz;
         if (poses_due.size() == 0) begin
            $error("pose item with none expected: x_pos %h", x);
            errors++;
            return;
         end
         pz = poses_due.pop_front();
         if (x !== pz.x) begin
            $error("x_pos: expected %h, actual %h", pz.x, x);
            errors++;
         end
         if (y !== pz.y) begin
            $error("y_pos: expected %h, actual %h", pz.y, y);
            errors++;
         end
         if (h !== pz.h) begin
            $error("heading: expected %h, actual %h", pz.h, h);
            errors++;
         end
      endfunction
   endclass

   logic                            clock;
   logic                            reset;
   logic                            csr_we;
   logic [ddo_pkg::CsrIdxWidth-1:0] csr_idx;
   logic [ddo_pkg::CsrWidth-1:0]    csr_wdata;
   ddo_req_if req ();
   ddo_rsp_if rsp ();

   odo_scoreboard sb = new();
   bit            steady;       // no idling on either side while set
   int            stall_ticks;
   logic [15:0]   cur_left, cur_right;

   differential_drive_odometry_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req.sink),
      .rsp       (rsp.source),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Result side: check accepted poses and stall at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) sb.check_pose(rsp.x_pos, rsp.y_pos, rsp.heading);
         rsp.ready <= steady || ($urandom_range(99) >= 13);
      end
   end

   // Watchdog on cycles without any accepted item.
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready))
         stall_ticks <= 0;
      else
         stall_ticks <= stall_ticks + 1;
      if (stall_ticks >= StallLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic write_csr(logic [ddo_pkg::CsrIdxWidth-1:0] idx,
                            logic [ddo_pkg::CsrWidth-1:0] v);
      csr_we    <= 1'b1;
      csr_idx   <= idx;
      csr_wdata <= v;
      sb.write_reg(idx, v);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Send one count item, with a random gap in front of it.
   task automatic send_counts(logic [15:0] lc, logic [15:0] rc, logic [15:0] gr);
      while (!steady && $urandom_range(99) < 13) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid       <= 1'b1;
      req.left_count  <= lc;
      req.right_count <= rc;
      req.gyro_rate   <= gr;
      do @(posedge clock); while (!req.ready);
      sb.note_item(lc, rc, gr);
      cur_left  = lc;
      cur_right = rc;
   endtask

   // Wait until every expected pose is back and the block has settled.
   task automatic drain();
      req.valid <= 1'b0;
      while (sb.poses_due.size() != 0) @(posedge clock);
      repeat (SettleTicks) @(posedge clock);
   endtask

   // Random counts: mostly small wheel motion, sometimes a jump anywhere.
   task automatic random_items(int n);
      logic [15:0] lc, rc;
      int          span;
      for (int k = 0; k < n; k++) begin
         steady = (k >= n / 3) && (k < n / 2);
         if ($urandom_range(99) < 20) begin
            lc = 16'($urandom);
            rc = 16'($urandom);
         end else begin
            span = ($urandom_range(9) == 0) ? 32767 : 400;
            lc = cur_left + 16'($urandom_range(2 * span) - span);
            rc = cur_right + 16'($urandom_range(2 * span) - span);
         end
         send_counts(lc, rc, 16'($urandom));
      end
      steady = 1'b0;
   endtask

   task automatic random_setting();
      write_csr(ddo_pkg::RegLeftStep, $urandom_range(4000));
      write_csr(ddo_pkg::RegRightStep, $urandom_range(4000));
      write_csr(ddo_pkg::RegTurnGain, $urandom);
      write_csr(ddo_pkg::RegUseGyro, $urandom);
      write_csr(ddo_pkg::RegGyroBias, $urandom);
      write_csr(ddo_pkg::RegGyroGain, $urandom_range(200000));
   endtask

   initial begin
      reset           = 1'b1;
      steady          = 1'b0;
      csr_we          = 1'b0;
      csr_idx         = '0;
      csr_wdata       = '0;
      req.valid       = 1'b0;
      req.left_count  = '0;
      req.right_count = '0;
      req.gyro_rate   = '0;
      cur_left        = '0;
      cur_right       = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset settings, count extremes and a wrap of exactly half range.
      send_counts(16'h0000, 16'h0000, 16'h0000);
      send_counts(16'h7FFF, 16'h8000, 16'h7FFF);
      send_counts(16'h8000, 16'h7FFF, 16'h8000);
      send_counts(16'h0000, 16'hFFFF, 16'h0000);
      send_counts(16'h0100, 16'h0180, 16'hFFFF);
      send_counts(16'h8100, 16'h8180, 16'h1234);
      drain();

      // Gyro mode with extreme bias and gain; wheels still give distance.
      write_csr(ddo_pkg::RegUseGyro, 1);
      write_csr(ddo_pkg::RegGyroBias, 32'h0000_8000);
      write_csr(ddo_pkg::RegGyroGain, 32'h00FF_FFFF);
      send_counts(16'h8200, 16'h8200, 16'h7FFF);
      send_counts(16'h8300, 16'h8350, 16'h8000);
      drain();
      write_csr(ddo_pkg::RegGyroBias, 32'h0000_7FFF);
      send_counts(16'h8400, 16'h8400, 16'h8000);
      send_counts(16'h8500, 16'h8450, 16'h7FFF);
      drain();

      // Extreme steps and gains; unknown indexes must change nothing.
      write_csr(ddo_pkg::RegUseGyro, 0);
      write_csr(ddo_pkg::RegLeftStep, 32'h00FF_FFFF);
      write_csr(ddo_pkg::RegRightStep, 32'h0000_0000);
      write_csr(ddo_pkg::RegTurnGain, 32'hFFFF_FFFF);
      write_csr(RegSpareLo, 32'hFFFF_FFFF);
      write_csr(RegSpareHi, 32'h0000_0001);
      send_counts(16'h0500, 16'h8500, 16'h5555);
      send_counts(16'h8500, 16'h0500, 16'hAAAA);
      drain();
      write_csr(ddo_pkg::RegLeftStep, 32'h0000_0000);
      write_csr(ddo_pkg::RegRightStep, 32'h00FF_FFFF);
      write_csr(ddo_pkg::RegTurnGain, 32'h0000_0000);
      send_counts(16'h0500, 16'h8500, 16'h0000);
      send_counts(16'h8501, 16'h0501, 16'h0000);
      drain();

      // Random phases over several settings, the extremes among them.
      random_items(150);
      drain();
      write_csr(ddo_pkg::RegLeftStep, 32'h00FF_FFFF);
      write_csr(ddo_pkg::RegRightStep, 32'h00FF_FFFF);
      random_items(150);
      drain();
      write_csr(ddo_pkg::RegUseGyro, 1);
      write_csr(ddo_pkg::RegGyroGain, 32'h0000_0000);
      random_items(100);
      drain();
      for (int ph = 0; ph < 4; ph++) begin
         random_setting();
         random_items(100);
         drain();
      end

      if (sb.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/ddo_pkg.sv
rtl/core/ddo_if.sv
rtl/core/ddo_serial_mul.sv
rtl/core/ddo_cordic.sv
rtl/core/differential_drive_odometry_top.sv
sim/differential_drive_odometry_top_tb.sv
